FILE: hw/rtl/secded_pkg.sv
// ----------------------------------------------------------------------------
// secded_pkg
// shared widths, check-row masks, opcodes and stage payload types for the
// (72,64) secded codec
// ----------------------------------------------------------------------------
package secded_pkg;

  localparam int DATA_W   = 64;
  localparam int CHECK_W  = 8;
  localparam int NUM_ROWS = 7;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int CODE_W   = DATA_W + CHECK_W;

  // hamming position limit, positions at or above this lie outside the code
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(CODE_W);

  // data masks for check bits 0..6
  localparam logic [DATA_W-1:0] CHECK_ROWS [NUM_ROWS] = '{
    64'hAB55_5555_56AA_AD5B,
    64'hCD99_9999_9B33_366D,
    64'hF1E1_E1E1_E3C3_C78E,
    64'h01FE_01FE_03FC_07F0,
    64'h01FF_FE00_03FF_F800,
    64'h01FF_FFFF_FC00_0000,
    64'hFE00_0000_0000_0000
  };

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_t;

  // after parity stage
  typedef struct packed {
    op_t                 op;
    logic [DATA_W-1:0]   data;
    logic [CHECK_W-1:0]  chk;
    logic [NUM_ROWS-1:0] low;
    logic                data_par;
  } par_t;

  // after correction stage
  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  data;
    logic [CHECK_W-1:0] check;
    logic               word_ok;
  } cor_t;

  // result beat
  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic               word_ok;
    logic [CHECK_W-1:0] check;
    logic [DATA_W-1:0]  data;
  } res_t;

endpackage

FILE: hw/rtl/secded_72_64_codec.sv
// ----------------------------------------------------------------------------
// secded_72_64_codec
// hamming (72,64) secded encoder / decoder, three-stage pipeline
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  --------+-----+---------------------------------------------+--------------
//  in_     | in  | data_word[63:0], check_byte[71:64]          | operation
//  out_    | out | result_data[63:0], result_check[71:64],     | word_valid
//          |     | result_length[78:72], zero pad [79]         |
//
//  one beat per clock sustained while the output is not stalled; each beat
//  passes three registered stages (row parities, syndrome and repair, bit length)
//  each stage register carries its own valid bit; a stage loads when it is
//  empty or when the stage after it moves, so a stalled output freezes only
//  the stages that are full behind it and no beat is lost or repeated
//  synchronous active-low reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module secded_72_64_codec (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // data_word[63:0], check_byte[71:64]
  input  logic        in_tuser,   // operation: 0 encode, 1 decode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // result_data, result_check, result_length, pad
  output logic        out_tuser   // word_valid
);
  import secded_pkg::*;

  // stage 1 -> 2
  logic par_valid;
  logic par_ready;
  par_t par_pay;

  // stage 2 -> 3
  logic cor_valid;
  logic cor_ready;
  cor_t cor_pay;

  res_t res_pay;
  op_t  in_op;

  assign in_op = op_t'(in_tuser);

  // row parities of the incoming data word
  secded_parity u_parity (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_op    (in_op),
    .s_data  (in_tdata[DATA_W-1:0]),
    .s_chk   (in_tdata[CODE_W-1:DATA_W]),
    .m_valid (par_valid),
    .m_ready (par_ready),
    .m_pay   (par_pay)
  );

  // check byte on encode, syndrome decode and single-bit flip on decode
  secded_correct u_correct (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (par_valid),
    .s_ready (par_ready),
    .s_pay   (par_pay),
    .m_valid (cor_valid),
    .m_ready (cor_ready),
    .m_pay   (cor_pay)
  );

  // bit length and the output register
  secded_length u_length (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (cor_valid),
    .s_ready (cor_ready),
    .s_pay   (cor_pay),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_pay   (res_pay)
  );

  // pack the result beat, pad bit is zero
  assign out_tdata = {1'b0, res_pay.length, res_pay.check, res_pay.data};
  assign out_tuser = res_pay.word_ok;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat valid after reset");

  // the pad bit stays clear on every output beat
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79] == 1'b0)
    else $error("pad bit set on output beat");

endmodule

FILE: hw/rtl/secded_parity.sv
// ----------------------------------------------------------------------------
// secded_parity
// stage 1: seven row parities and the overall data parity
// ----------------------------------------------------------------------------
module secded_parity (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s_valid,
  output logic                        s_ready,
  input  secded_pkg::op_t             s_op,
  input  logic [secded_pkg::DATA_W-1:0]  s_data,
  input  logic [secded_pkg::CHECK_W-1:0] s_chk,
  output logic                        m_valid,
  input  logic                        m_ready,
  output secded_pkg::par_t            m_pay
);
  import secded_pkg::*;

  logic valid_r;
  par_t pay_r;
  par_t pay_nxt;

  always_comb begin
    pay_nxt.op       = s_op;
    pay_nxt.data     = s_data;
    pay_nxt.chk      = s_chk;
    for (int j = 0; j < NUM_ROWS; j++) begin
      pay_nxt.low[j] = ^(s_data & CHECK_ROWS[j]);
    end
    pay_nxt.data_par = ^s_data;
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      pay_r <= pay_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_pay   = pay_r;

endmodule

FILE: hw/rtl/secded_correct.sv
// ----------------------------------------------------------------------------
// secded_correct
// stage 2: check byte for encode, syndrome and single-bit repair for decode
// ----------------------------------------------------------------------------
module secded_correct (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  secded_pkg::par_t s_pay,
  output logic             m_valid,
  input  logic             m_ready,
  output secded_pkg::cor_t m_pay
);
  import secded_pkg::*;

  logic               valid_r;
  cor_t               pay_r;
  cor_t               pay_nxt;
  logic [CHECK_W-1:0] synd;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pw;
  logic [POS_W-1:0]   bit_idx;
  logic               pos_pow2;

  assign synd     = {s_pay.data_par ^ (^s_pay.chk), s_pay.low ^ s_pay.chk[NUM_ROWS-1:0]};
  assign pos      = synd[POS_W-1:0];
  assign pos_pow2 = (pos & (pos - POS_W'(1))) == '0;

  // number of check positions at or below pos, for pos of two and above
  always_comb begin
    priority if (pos < POS_W'(4))  pw = POS_W'(2);
    else if (pos < POS_W'(8))      pw = POS_W'(3);
    else if (pos < POS_W'(16))     pw = POS_W'(4);
    else if (pos < POS_W'(32))     pw = POS_W'(5);
    else if (pos < POS_W'(64))     pw = POS_W'(6);
    else                           pw = POS_W'(7);
  end

  assign bit_idx = pos - pw - POS_W'(1);

  always_comb begin
    pay_nxt.op      = s_pay.op;
    pay_nxt.data    = s_pay.data;
    pay_nxt.check   = '0;
    pay_nxt.word_ok = 1'b1;
    unique case (s_pay.op)
      OP_ENCODE: begin
        pay_nxt.check = {s_pay.data_par ^ (^s_pay.low), s_pay.low};
      end
      OP_DECODE: begin
        if (synd == '0) begin
          pay_nxt.word_ok = 1'b1;
        end else if (synd[CHECK_W-1]) begin
          if (pos >= POS_LIMIT) begin
            pay_nxt.word_ok = 1'b0;
          end else if (!pos_pow2) begin
            pay_nxt.data[bit_idx[5:0]] = ~s_pay.data[bit_idx[5:0]];
          end
        end else begin
          pay_nxt.word_ok = 1'b0;
        end
      end
      default: pay_nxt.word_ok = 1'b1;
    endcase
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      pay_r <= pay_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_pay   = pay_r;

  // an encoded codeword always has even overall parity
  a_enc_parity: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && pay_r.op == OP_ENCODE |-> (^{pay_r.data, pay_r.check}) == 1'b0)
    else $error("encode codeword parity odd");

  // decode never produces a check byte, encode never flags an error
  a_op_fields: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (pay_r.op == OP_ENCODE && pay_r.word_ok) ||
                (pay_r.op == OP_DECODE && pay_r.check == '0))
    else $error("result fields disagree with operation");

endmodule

FILE: hw/rtl/secded_length.sv
// ----------------------------------------------------------------------------
// secded_length
// stage 3: bit length of the result value and the output register
// ----------------------------------------------------------------------------
module secded_length (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  secded_pkg::cor_t s_pay,
  output logic             m_valid,
  input  logic             m_ready,
  output secded_pkg::res_t m_pay
);
  import secded_pkg::*;

  logic              valid_r;
  res_t              pay_r;
  res_t              pay_nxt;
  logic [CODE_W-1:0] value;
  logic [LEN_W-1:0]  len;

  // encode measures the whole codeword, decode the data alone
  assign value = (s_pay.op == OP_ENCODE) ? {s_pay.data, s_pay.check}
                                         : {{CHECK_W{1'b0}}, s_pay.data};

  always_comb begin
    len = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (value[i]) begin
        len = LEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    pay_nxt.length  = len;
    pay_nxt.word_ok = s_pay.word_ok;
    pay_nxt.check   = s_pay.check;
    pay_nxt.data    = s_pay.data;
  end

  assign s_ready = !valid_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      pay_r <= pay_nxt;
    end
  end

  assign m_valid = valid_r;
  assign m_pay   = pay_r;

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> pay_r.length <= LEN_W'(CODE_W))
    else $error("bit length beyond codeword");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && pay_r.length == '0 |-> pay_r.data == '0 && pay_r.check == '0)
    else $error("zero length on nonzero result");

endmodule

FILE: tb/secded_72_64_codec_tb.sv
// ----------------------------------------------------------------------------
// secded_72_64_codec_tb
// self-checking bench for the (72,64) secded encoder / decoder
// ----------------------------------------------------------------------------
// input beats are directed corner words first, then random encodes, clean
// codewords, single and double bit errors, syndromes that point past the code
// and raw garbage. each accepted beat goes to a scoreboard that predicts the
// result beat on its own; result beats are checked in order, field by field.
// both stream sides idle at random in two phases, and one long receiver
// hold-off fills the pipeline while the sender keeps offering beats.
// ----------------------------------------------------------------------------
module secded_72_64_codec_tb;
  import secded_pkg::*;

  // data masks for check bits 0..6
  localparam logic [63:0] ROW_MASK [7] = '{
    64'hAB55_5555_56AA_AD5B,
    64'hCD99_9999_9B33_366D,
    64'hF1E1_E1E1_E3C3_C78E,
    64'h01FE_01FE_03FC_07F0,
    64'h01FF_FE00_03FF_F800,
    64'h01FF_FFFF_FC00_0000,
    64'hFE00_0000_0000_0000
  };

  // hamming positions 72 and above lie outside the code
  localparam int CODE_POSITIONS = 72;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int PIPE_SETTLE    = 10;

  // --------------------------------------------------------------------------
  // scoreboard: predicts one result beat per input beat, checks them in order
  // --------------------------------------------------------------------------
  class secded_board;
    typedef struct {
      logic [63:0] data;
      logic [7:0]  check;
      logic        valid;
      logic [6:0]  length;
    } codec_result_t;

    codec_result_t expected_results[$];
    int mismatch_count  = 0;
    int beats_checked   = 0;
    int encodes         = 0;
    int clean_words     = 0;
    int corrected_words = 0;
    int bad_words       = 0;

    function logic [6:0] row_checks(logic [63:0] d);
      logic [6:0] c;
      int j;
      for (j = 0; j < 7; j++) c[j] = ^(d & ROW_MASK[j]);
      return c;
    endfunction

    function logic [6:0] bit_length(logic [71:0] v);
      int n;
      int i;
      n = 0;
      for (i = 0; i < 72; i++) if (v[i]) n = i + 1;
      return 7'(n);
    endfunction

    function codec_result_t compute_codec_result(op_t op, logic [63:0] d,
                                                 logic [7:0] chk);
      codec_result_t r;
      logic [6:0] low;
      logic [7:0] syn;
      int p;
      int pw;
      int t;
      r.data  = d;
      r.check = 8'h00;
      r.valid = 1'b1;
      if (op == OP_ENCODE) begin
        low     = row_checks(d);
        r.check = {(^d) ^ (^low), low};
        // length of the whole 72-bit codeword
        r.length = bit_length({d, r.check});
      end else begin
        syn = {(^d) ^ (^chk), row_checks(d) ^ chk[6:0]};
        if (syn == 8'h00) begin
          r.valid = 1'b1;
        end else if (syn[7]) begin
          p = int'(syn[6:0]);
          if (p >= CODE_POSITIONS) begin
            r.valid = 1'b0;
          end else begin
            // data bits sit at non power-of-two positions
            if (p != 0 && (p & (p - 1)) != 0) begin
              pw = 0;
              for (t = 1; t <= p; t = t << 1) pw++;
              r.data[p - pw - 1] = ~r.data[p - pw - 1];
            end
            r.valid = 1'b1;
          end
        end else begin
          r.valid = 1'b0;
        end
        r.length = bit_length({8'h00, r.data});
      end
      return r;
    endfunction

    function void note_beat(op_t op, logic [71:0] word);
      codec_result_t r;
      r = compute_codec_result(op, word[63:0], word[71:64]);
      expected_results.push_back(r);
      if (op == OP_ENCODE) encodes++;
      else if (!r.valid) bad_words++;
      else if (r.data != word[63:0] || word[71:64] != {(^word[63:0]) ^
               (^row_checks(word[63:0])), row_checks(word[63:0])}) corrected_words++;
      else clean_words++;
    endfunction

    function void check_beat(logic [63:0] data, logic [7:0] check,
                             logic valid, logic [6:0] length);
      codec_result_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending: data %h", data);
        mismatch_count++;
        return;
      end
      e = expected_results.pop_front();
      beats_checked++;
      if (data !== e.data) begin
        $error("result_data mismatch: expected %h, got %h", e.data, data);
        mismatch_count++;
      end
      if (check !== e.check) begin
        $error("result_check mismatch: expected %h, got %h", e.check, check);
        mismatch_count++;
      end
      if (valid !== e.valid) begin
        $error("word_valid mismatch: expected %0b, got %0b", e.valid, valid);
        mismatch_count++;
      end
      if (length !== e.length) begin
        $error("result_length mismatch: expected %0d, got %0d", e.length, length);
        mismatch_count++;
      end
    endfunction

    function void drain_check();
      if (expected_results.size() != 0) begin
        $error("%0d result beats never arrived", expected_results.size());
        mismatch_count += expected_results.size();
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;   // data_word[63:0], check_byte[71:64]
  logic        in_tuser   = 1'b0; // operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;         // result_data, result_check, result_length, pad
  logic        out_tuser;         // word_valid

  // idle odds per cycle, in percent
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off, requested by the stimulus and counted below
  bit hold_request = 1'b0;
  int hold_left    = 0;

  secded_board board = new();

  secded_72_64_codec i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random back-pressure, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // result monitor, samples the values that held before the edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_beat(out_tdata[63:0], out_tdata[71:64], out_tuser, out_tdata[78:72]);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    logic [63:0] d;
    d = {$urandom(), $urandom()};
    // sparse words now and then so result lengths spread out
    if ($urandom_range(0, 9) == 0) d = d >> $urandom_range(0, 63);
    return d;
  endfunction

  // clean codeword as it sits on tdata: check byte above the data
  function automatic logic [71:0] codeword_of(logic [63:0] d);
    secded_board::codec_result_t r;
    r = board.compute_codec_result(OP_ENCODE, d, 8'h00);
    return {r.check, d};
  endfunction

  // overall parity wrong and low syndrome pointing at hamming position p
  function automatic logic [71:0] syndrome_word(logic [63:0] d, int p);
    logic [7:0] chk;
    chk[6:0] = board.row_checks(d) ^ 7'(p);
    chk[7]   = ~((^d) ^ (^chk[6:0]));
    return {chk, d};
  endfunction

  // one beat: optional idle gap, then hold valid until the handshake
  task automatic send_beat(op_t op, logic [71:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_beat(op, word);
  endtask

  // sender pauses until every pending result beat is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic directed_beats();
    logic [71:0] w;
    // encode corners, the check byte must be ignored
    send_beat(OP_ENCODE, {8'h00, 64'h0});
    send_beat(OP_ENCODE, {8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_beat(OP_ENCODE, {8'hA5, 64'h1});
    send_beat(OP_ENCODE, {8'h00, 64'h8000_0000_0000_0000});
    // clean codewords pass through valid
    send_beat(OP_DECODE, codeword_of(64'h0));
    send_beat(OP_DECODE, codeword_of(64'hFFFF_FFFF_FFFF_FFFF));
    send_beat(OP_DECODE, codeword_of(64'h0123_4567_89AB_CDEF));
    // single data bit errors at both ends
    w = codeword_of(64'hFFFF_FFFF_FFFF_FFFF);
    send_beat(OP_DECODE, w ^ (72'd1 << 0));
    send_beat(OP_DECODE, w ^ (72'd1 << 63));
    // single check bit errors, low row, top row and the overall parity bit
    send_beat(OP_DECODE, w ^ (72'd1 << 64));
    send_beat(OP_DECODE, w ^ (72'd1 << 70));
    send_beat(OP_DECODE, w ^ (72'd1 << 71));
    // double errors: two data bits, data plus check bit
    w = codeword_of(64'hDEAD_BEEF_0BAD_F00D);
    send_beat(OP_DECODE, w ^ (72'd1 << 5) ^ (72'd1 << 40));
    send_beat(OP_DECODE, w ^ (72'd1 << 12) ^ (72'd1 << 66));
    // syndrome past the last position of the code
    send_beat(OP_DECODE, syndrome_word(64'h0, CODE_POSITIONS));
    send_beat(OP_DECODE, syndrome_word(64'hFFFF_FFFF_FFFF_FFFF, 127));
    // overall parity set with position zero, and position of a check bit
    send_beat(OP_DECODE, syndrome_word(64'h5555_AAAA_5555_AAAA, 0));
    send_beat(OP_DECODE, syndrome_word(64'h5555_AAAA_5555_AAAA, 32));
    // garbage words
    send_beat(OP_DECODE, {8'hFF, 64'h0});
    send_beat(OP_DECODE, {8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_beat(OP_DECODE, {8'h00, 64'hFFFF_FFFF_FFFF_FFFF});
  endtask

  task automatic random_beats(int count);
    logic [71:0] w;
    int sel;
    int i;
    int j;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      w   = codeword_of(rand_word());
      if (sel < 20) begin
        send_beat(OP_ENCODE, {8'($urandom()), w[63:0]});
      end else if (sel < 38) begin
        send_beat(OP_DECODE, w);
      end else if (sel < 65) begin
        // single error anywhere in the 72 bits
        send_beat(OP_DECODE, w ^ (72'd1 << $urandom_range(0, 71)));
      end else if (sel < 80) begin
        // double error, two distinct bits
        i = $urandom_range(0, 71);
        j = (i + $urandom_range(1, 71)) % 72;
        send_beat(OP_DECODE, w ^ (72'd1 << i) ^ (72'd1 << j));
      end else if (sel < 88) begin
        send_beat(OP_DECODE,
                  syndrome_word(w[63:0], $urandom_range(CODE_POSITIONS, 127)));
      end else begin
        send_beat(OP_DECODE, {8'($urandom()), rand_word()});
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_beats();
    wait_drained();

    // busy sender, slow receiver
    send_idle_pct = 16;
    recv_idle_pct = 86;
    random_beats(550);
    wait_drained();

    // slow sender, busy receiver
    send_idle_pct = 86;
    recv_idle_pct = 16;
    random_beats(550);
    wait_drained();

    // no idling; first a long receiver hold-off to back the pipeline up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    random_beats(40);
    random_beats(510);

    in_tvalid <= 1'b0;
    waited = 0;
    while (board.expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SETTLE) @(posedge clk);
    board.drain_check();

    $display("run covered %0d encodes and %0d decodes (%0d clean, %0d corrected, %0d uncorrectable)",
             board.encodes, board.clean_words + board.corrected_words + board.bad_words,
             board.clean_words, board.corrected_words, board.bad_words);
    $display("%0d result beats checked under three idle patterns and one long stall",
             board.beats_checked);
    if (board.mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/secded_pkg.sv
hw/rtl/secded_parity.sv
hw/rtl/secded_correct.sv
hw/rtl/secded_length.sv
hw/rtl/secded_72_64_codec.sv
tb/secded_72_64_codec_tb.sv
